// File: sv/assert_macros.svh
// Assertion helpers, clocked on clk with arst_n as the disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define EVPP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define EVPP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define EVPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/evpp_pkg.sv
package evpp_pkg;

	localparam int unsigned TABLE_SIZE_DEF = 1024;

	localparam int unsigned CMD_W  = 2;
	localparam int unsigned SLOT_W = 10;
	localparam int unsigned STAT_W = 32;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned PV_W   = 17;
	localparam int unsigned CIDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [CIDX_W-1:0] REG_TAIL_MODE    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_ACTIVE_COUNT = 2'd1;
	localparam logic [CIDX_W-1:0] REG_INIT_VALUE   = 2'd2;

	localparam logic [CNT_W-1:0] ACTIVE_COUNT_RST = 11'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_SCAN,
		ST_DIV,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W:0]   num;
		logic [CNT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [PV_W-1:0] quot;
	} div_rsp_t;

	// a more extreme than b: greater in upper tail, smaller in lower tail
	function automatic logic more_extreme(input logic tail, input logic [STAT_W-1:0] a,
			input logic [STAT_W-1:0] b);
		logic res;
		if (tail) begin
			res = $signed(a) < $signed(b);
		end else begin
			res = $signed(a) > $signed(b);
		end
		return res;
	endfunction

endpackage

// File: sv/evpp_ram.sv
module evpp_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/evpp_div.sv
module evpp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  evpp_pkg::div_req_t  req,
	output evpp_pkg::div_rsp_t  rsp
);
	import evpp_pkg::*;

	localparam int unsigned STEP_W = $clog2(PV_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [PV_W-1:0]   quot_q;

	logic              ge;
	logic [CNT_W:0]    diff;
	logic [CNT_W:0]    rem_sel;

	// restoring step; remainder stays below the divisor so the shift fits
	always_comb begin
		diff    = rem_q - {1'b0, den_q};
		ge      = rem_q >= {1'b0, den_q};
		rem_sel = ge ? diff : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(PV_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q  <= {rem_sel[CNT_W-1:0], 1'b0};
			quot_q <= {quot_q[PV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// File: sv/extreme_value_permutation_pvalue.sv
// Extreme-value permutation table with empirical p-value.
// Input channel (in_valid/in_ready, cmd/slot/statistic) takes one word at a
// time: update keeps the more extreme of stored and new value, clear writes
// init_value, query counts active slots more extreme than statistic.
// Output channel (out_valid/out_ready) returns one word per input word:
// replaced, rank, slot_count and p_value (Q1.16, rank * 65536 / count).
// Config channel (cfg_valid/cfg_ready, always ready) writes tail_mode,
// active_count and init_value by index; write only while the block is idle.
// Clear and unused command go to the response state at once, update passes
// a read-compare state first, query scans (one slot memory read per cycle,
// then a bit-serial divide), or responds at once if the table is empty.
// The slot memory's single read port sets the query rate.
// A new word is taken once the previous one has reached the output register,
// even if the receiver has not yet taken that result.
// If the receiver stalls, the finished result is held and the block waits
// with the next result until the output register frees.
// Reset: tail_mode 0, active_count 1024, init_value 0; slots are undefined
// until cleared or updated, so no clearing pass runs after reset.
`include "assert_macros.svh"

module extreme_value_permutation_pvalue #(
	parameter int unsigned TABLE_SIZE = evpp_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [evpp_pkg::CMD_W-1:0]    cmd,
	input  logic [evpp_pkg::SLOT_W-1:0]   slot,
	input  logic [evpp_pkg::STAT_W-1:0]   statistic,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          replaced,
	output logic [evpp_pkg::CNT_W-1:0]    rank,
	output logic [evpp_pkg::CNT_W-1:0]    slot_count,
	output logic [evpp_pkg::PV_W-1:0]     p_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [evpp_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [evpp_pkg::STAT_W-1:0]   cfg_data
);
	import evpp_pkg::*;

	localparam int unsigned AW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	// largest count the 11-bit register can ask for, limited by the table
	localparam int unsigned CAP = (TABLE_SIZE < (1 << CNT_W)) ? TABLE_SIZE : (1 << CNT_W) - 1;

	// configuration registers
	logic              tail_q;
	logic [CNT_W-1:0]  active_q;
	logic [STAT_W-1:0] init_q;

	// control
	state_t state_q, state_d;
	logic   accept;
	logic   out_free;
	logic   cmp_vld_q;
	logic   issue;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] more_q;

	// captured word
	logic [SLOT_W-1:0] slot_q;
	logic [STAT_W-1:0] stat_q;
	logic              upd_ok_q;

	// result being built
	logic              replaced_q;
	logic [CNT_W-1:0]  rank_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PV_W-1:0]   quot_q;

	// output register
	logic              out_valid_q;
	logic              out_replaced_q;
	logic [CNT_W-1:0]  out_rank_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [PV_W-1:0]   out_pv_q;

	// memory port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [STAT_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [STAT_W-1:0] ram_rdata;

	logic [CNT_W-1:0]  count_eff;
	logic              slot_ok;
	logic              upd_hit;
	logic [CNT_W:0]    more_p1;
	logic [CNT_W-1:0]  rank_calc;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// ---------------------------------------------------------------
	// Config port: always ready, unknown indexes ignored
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q   <= 1'b0;
			active_q <= ACTIVE_COUNT_RST;
			init_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TAIL_MODE:    tail_q   <= cfg_data[0];
				REG_ACTIVE_COUNT: active_q <= cfg_data[CNT_W-1:0];
				REG_INIT_VALUE:   init_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Shared combinational terms
	// ---------------------------------------------------------------
	always_comb begin
		count_eff = (active_q > CNT_W'(CAP)) ? CNT_W'(CAP) : active_q;
		slot_ok   = {1'b0, slot} < count_eff;
		out_free  = !out_valid_q || out_ready;
		accept    = in_valid && in_ready;
		// read data in UPD is the stored value of slot_q
		upd_hit   = upd_ok_q && more_extreme(tail_q, stat_q, ram_rdata);
		issue     = idx_q < count_eff;
		more_p1   = {1'b0, more_q} + 1'b1;
		rank_calc = (more_p1 > {1'b0, count_eff}) ? count_eff : more_p1[CNT_W-1:0];
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = AW'(slot_q);
		ram_wdata     = stat_q;
		ram_raddr     = AW'(idx_q);
		div_req.start = 1'b0;
		div_req.num   = {1'b0, rank_calc};
		div_req.den   = count_eff;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = (cmd == CMD_QUERY) ? '0 : AW'(slot);
				// clear writes straight away from the input word
				ram_waddr = AW'(slot);
				ram_wdata = init_q;
				ram_we    = in_valid && (cmd == CMD_CLEAR) && slot_ok;
				if (in_valid) begin
					case (cmd)
						CMD_UPDATE: state_d = ST_UPD;
						CMD_QUERY:  state_d = (count_eff != '0) ? ST_SCAN : ST_RESP;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_UPD: begin
				ram_we  = upd_hit;
				state_d = ST_RESP;
			end
			ST_SCAN: begin
				// pipeline drained: every active slot compared
				if (!cmp_vld_q) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Scan control
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_q <= 1'b0;
			idx_q     <= '0;
			more_q    <= '0;
		end else if (accept) begin
			// slot 0 is read in the accept cycle
			cmp_vld_q <= (cmd == CMD_QUERY) && (count_eff != '0);
			idx_q     <= CNT_W'(1);
			more_q    <= '0;
		end else if (state_q == ST_SCAN) begin
			cmp_vld_q <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmp_vld_q && more_extreme(tail_q, ram_rdata, stat_q)) begin
				more_q <= more_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Word capture and result assembly
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q     <= slot;
			stat_q     <= statistic;
			upd_ok_q   <= slot_ok;
			replaced_q <= 1'b0;
			rank_q     <= '0;
			cnt_q      <= '0;
			quot_q     <= '0;
		end else begin
			if (state_q == ST_UPD) begin
				replaced_q <= upd_hit;
			end
			if (state_q == ST_SCAN && !cmp_vld_q) begin
				rank_q <= rank_calc;
				cnt_q  <= count_eff;
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				quot_q <= div_rsp.quot;
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			out_replaced_q <= replaced_q;
			out_rank_q     <= rank_q;
			out_cnt_q      <= cnt_q;
			out_pv_q       <= quot_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign replaced   = out_replaced_q;
	assign rank       = out_rank_q;
	assign slot_count = out_cnt_q;
	assign p_value    = out_pv_q;

	// ---------------------------------------------------------------
	// Units
	// ---------------------------------------------------------------
	evpp_ram #(
		.WIDTH  (STAT_W),
		.DEPTH  (TABLE_SIZE),
		.ADDR_W (AW)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	evpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`EVPP_ASSERT_IMPL(a_wr_state, ram_we, (state_q == ST_IDLE) || (state_q == ST_UPD), "slot write outside clear or update")
	`EVPP_ASSERT_IMPL(a_more_bound, state_q == ST_SCAN, more_q <= idx_q, "more-extreme count ahead of reads issued")
	`EVPP_ASSERT_IMPL(a_div_done, div_rsp.done, state_q == ST_DIV, "divider finished outside divide state")
	`EVPP_ASSERT_NEXT(a_out_load, (state_q == ST_RESP) && out_free, out_valid_q && (state_q == ST_IDLE), "result not presented after response")

endmodule
